### rtl/sqlpm_pkg.sv
package sqlpm_pkg;

    localparam int DEF_MAX_TAG_CHARS     = 30;
    localparam int DEF_MAX_COMMENT_DEPTH = 255;
    localparam int DEF_MAX_MARKERS       = 65535;

    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_CMP_W  = 17;
    localparam int BEAT_W     = 3;
    localparam int EXP_W      = 16;

    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

    localparam logic REG_EXPECTED = 1'b0;

    typedef struct packed {
        logic              marker;
        logic [7:0]        byte_v;
        logic [BCD_W-1:0]  bcd;
        logic [BEAT_W-1:0] nbeats;
        logic              too_long;
        logic              done;
        logic              mismatch;
    } t_run;

endpackage

### rtl/sqlpm_lexer.sv
module sqlpm_lexer
    import sqlpm_pkg::*;
#(
    parameter int MAX_TAG_CHARS     = DEF_MAX_TAG_CHARS,
    parameter int MAX_COMMENT_DEPTH = DEF_MAX_COMMENT_DEPTH,
    parameter int MAX_MARKERS       = DEF_MAX_MARKERS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_text_byte,
    input  logic             i_statement_end,
    input  logic [EXP_W-1:0] i_expected,
    output t_run             o_run
);

    localparam int WIN = MAX_TAG_CHARS + 2;
    localparam int LW  = $clog2(WIN + 1);
    localparam int DW  = $clog2(MAX_COMMENT_DEPTH + 1);
    localparam int TW  = $clog2(MAX_MARKERS + 2);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_SQUOTE = 3'd1,
        M_DQUOTE = 3'd2,
        M_LINE   = 3'd3,
        M_BLOCK  = 3'd4,
        M_DOLLAR = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        P_NONE   = 3'd0,
        P_DASH   = 3'd1,
        P_SLASH  = 3'd2,
        P_STAR   = 3'd3,
        P_QUOTE  = 3'd4,
        P_ESCAPE = 3'd5,
        P_DOLLAR = 3'd6,
        P_TAG    = 3'd7
    } t_pend;

    t_mode            r_mode, n_mode;
    t_pend            r_pk, n_pk;
    logic [DW-1:0]    r_depth, n_depth;
    logic [TW-1:0]    r_total, n_total;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [LW-1:0]    r_dlen, n_dlen;
    logic [LW-1:0]    r_bso, n_bso;
    logic [7:0]       r_dl  [WIN];
    logic [7:0]       r_win [WIN];
    logic [7:0]       win_new [WIN];

    logic [7:0] c;
    logic       is_letter, is_word;
    logic       dl_push;
    logic [7:0] dl_byte;
    logic       win_push;
    logic       too_long;
    logic       do_plain;
    logic       marker;
    logic       match_all;
    logic       hit;
    logic [7:0] q;
    logic       carry;
    logic [3:0] dig;
    logic [2:0] ndig;
    logic       bad;

    assign c = i_text_byte;
    assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                       c == CH_UNDER;
    assign is_word = is_letter || (c >= 8'h30 && c <= 8'h39);
    assign q = (r_mode == M_SQUOTE) ? CH_SQUOTE : CH_DQUOTE;

    always_comb begin
        win_new[0] = c;
        for (int j = 1; j < WIN; j++) begin
            win_new[j] = r_win[j-1];
        end
        match_all = 1'b1;
        for (int j = 0; j < WIN; j++) begin
            if (LW'(j) < r_dlen && win_new[j] != r_dl[j]) begin
                match_all = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_pk     = r_pk;
        n_depth  = r_depth;
        n_dlen   = r_dlen;
        n_bso    = r_bso;
        dl_push  = 1'b0;
        dl_byte  = CH_DOLLAR;
        win_push = 1'b0;
        too_long = 1'b0;
        do_plain = 1'b0;
        marker   = 1'b0;
        hit      = 1'b0;
        case (r_mode)
            M_NORMAL: begin
                if (r_pk == P_DASH && c == CH_DASH) begin
                    n_pk   = P_NONE;
                    n_mode = M_LINE;
                end else if (r_pk == P_SLASH && c == CH_STAR) begin
                    n_pk    = P_NONE;
                    n_mode  = M_BLOCK;
                    n_depth = DW'(1);
                end else if ((r_pk == P_DOLLAR || r_pk == P_TAG) && c == CH_DOLLAR) begin
                    if (r_dlen < LW'(WIN)) begin
                        dl_push = 1'b1;
                        n_dlen  = r_dlen + LW'(1);
                    end
                    n_mode = M_DOLLAR;
                    n_pk   = P_NONE;
                    n_bso  = '0;
                end else if ((r_pk == P_DOLLAR && is_letter) || (r_pk == P_TAG && is_word)) begin
                    n_pk = P_NONE;
                    if (r_dlen >= LW'(WIN - 1)) begin
                        too_long = 1'b1;
                        n_dlen   = '0;
                    end else begin
                        dl_push = 1'b1;
                        dl_byte = c;
                        n_dlen  = r_dlen + LW'(1);
                        n_pk    = P_TAG;
                    end
                end else begin
                    do_plain = 1'b1;
                end
            end
            M_SQUOTE, M_DQUOTE: begin
                if (r_pk == P_QUOTE) begin
                    n_pk = P_NONE;
                    if (c != q) begin
                        n_mode   = M_NORMAL;
                        do_plain = 1'b1;
                    end
                end else if (r_pk == P_ESCAPE) begin
                    n_pk = P_NONE;
                end else if (c == q) begin
                    n_pk = P_QUOTE;
                end else if (c == CH_BSLASH) begin
                    n_pk = P_ESCAPE;
                end else begin
                    n_pk = P_NONE;
                end
            end
            M_LINE: begin
                n_pk = P_NONE;
                if (c == CH_LF) begin
                    n_mode = M_NORMAL;
                end
            end
            M_BLOCK: begin
                if (r_pk == P_SLASH && c == CH_STAR) begin
                    n_pk = P_NONE;
                    if (r_depth < DW'(MAX_COMMENT_DEPTH)) begin
                        n_depth = r_depth + DW'(1);
                    end
                end else if (r_pk == P_STAR && c == CH_SLASH) begin
                    n_pk = P_NONE;
                    if (r_depth != '0) begin
                        n_depth = r_depth - DW'(1);
                    end
                    if (n_depth == '0) begin
                        n_mode = M_NORMAL;
                    end
                end else if (c == CH_SLASH) begin
                    n_pk = P_SLASH;
                end else if (c == CH_STAR) begin
                    n_pk = P_STAR;
                end else begin
                    n_pk = P_NONE;
                end
            end
            M_DOLLAR: begin
                win_push = 1'b1;
                if (r_bso < LW'(WIN)) begin
                    n_bso = r_bso + LW'(1);
                end
                hit = r_dlen != '0 && n_bso >= r_dlen && match_all;
                if (hit) begin
                    n_mode = M_NORMAL;
                    n_pk   = P_NONE;
                    n_dlen = '0;
                end
            end
            default: begin
                n_mode   = M_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            n_pk = P_NONE;
            if (c == CH_SQUOTE) begin
                n_mode = M_SQUOTE;
            end else if (c == CH_DQUOTE) begin
                n_mode = M_DQUOTE;
            end else if (c == CH_DASH) begin
                n_pk = P_DASH;
            end else if (c == CH_SLASH) begin
                n_pk = P_SLASH;
            end else if (c == CH_DOLLAR) begin
                dl_push = 1'b1;
                n_dlen  = LW'(1);
                n_pk    = P_DOLLAR;
            end else if (c == CH_QMARK) begin
                marker = 1'b1;
            end
        end
    end

    always_comb begin
        n_total = r_total;
        n_bcd   = r_bcd;
        carry   = 1'b1;
        dig     = '0;
        if (marker) begin
            if (r_total < TW'(MAX_MARKERS)) begin
                n_total = r_total + TW'(1);
                for (int k = 0; k < BCD_DIGITS; k++) begin
                    dig = r_bcd[4*k +: 4] + {3'b000, carry};
                    carry = dig > 4'd9;
                    n_bcd[4*k +: 4] = carry ? 4'd0 : dig;
                end
            end else begin
                n_total = TW'(MAX_MARKERS + 1);
            end
        end
        ndig = 3'd1;
        for (int k = 1; k < BCD_DIGITS; k++) begin
            if (n_bcd[4*k +: 4] != 4'd0) begin
                ndig = 3'(k + 1);
            end
        end
        bad = CNT_CMP_W'(n_total) > CNT_CMP_W'(MAX_MARKERS) ||
              (n_total != '0 && CNT_CMP_W'(n_total) != CNT_CMP_W'(i_expected));
    end

    always_comb begin
        o_run.marker   = marker;
        o_run.byte_v   = c;
        o_run.bcd      = n_bcd;
        o_run.nbeats   = marker ? BEAT_W'(ndig + 3'd1) : BEAT_W'(1);
        o_run.too_long = too_long;
        o_run.done     = i_statement_end;
        o_run.mismatch = i_statement_end && bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_pk    <= P_NONE;
            r_depth <= '0;
            r_total <= '0;
            r_bcd   <= '0;
            r_dlen  <= '0;
            r_bso   <= '0;
        end else if (i_accept) begin
            if (i_statement_end) begin
                r_mode  <= M_NORMAL;
                r_pk    <= P_NONE;
                r_depth <= '0;
                r_total <= '0;
                r_bcd   <= '0;
                r_dlen  <= '0;
                r_bso   <= '0;
            end else begin
                r_mode  <= n_mode;
                r_pk    <= n_pk;
                r_depth <= n_depth;
                r_total <= n_total;
                r_bcd   <= n_bcd;
                r_dlen  <= n_dlen;
                r_bso   <= n_bso;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && dl_push) begin
            r_dl[0] <= dl_byte;
            for (int j = 1; j < WIN; j++) begin
                r_dl[j] <= r_dl[j-1];
            end
        end
        if (i_accept && win_push) begin
            r_win <= win_new;
        end
    end

endmodule

### rtl/sql_parameter_marker_rewriter_unit.sv
// SQL parameter marker rewriter.
// Input stream: one text byte per beat on i_s_tdata, i_s_tlast on the final
// byte of a statement. Output stream: one byte per beat on o_m_tdata; each
// '?' in plain text leaves as '$' and its decimal number (two to six beats),
// every other byte leaves unchanged as one beat. o_m_tlast marks the last beat
// caused by one input byte; o_m_tuser carries the statement end, the count
// mismatch verdict and the long dollar tag flag.
// An accepted byte is registered in the output beat register, or in the
// one-deep queue behind it while that register is busy. Throughput: one
// byte per cycle while bytes are echoed and i_m_tready is high; a marker
// holds the single output beat register until all its beats have left. The
// lexer state updates on every accepted byte; input is taken whenever the queue is empty.
// Stall: a low i_m_tready holds the current beat; one more byte is still
// accepted into the queue, then o_s_tready drops until the output drains.
// Reset clears the lexer state, the queue and the output; the expected
// marker count register resets to zero. The user must write it over the APB
// port only while the stream is idle; the block itself does not enforce this.
module sql_parameter_marker_rewriter_unit
    import sqlpm_pkg::*;
#(
    parameter int MAX_TAG_CHARS     = DEF_MAX_TAG_CHARS,
    parameter int MAX_COMMENT_DEPTH = DEF_MAX_COMMENT_DEPTH,
    parameter int MAX_MARKERS       = DEF_MAX_MARKERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] text_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,
    output logic [2:0]  o_m_tuser,   // [0] statement_done [1] count_mismatch [2] tag_too_long
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [EXP_W-1:0]  r_expected;
    t_run              run;
    t_run              r_a, r_b;
    logic              r_a_valid, r_b_valid;
    logic [BEAT_W-1:0] r_beat;
    logic              accept;
    logic              a_last_beat, a_done, a_free;
    logic [BEAT_W-1:0] dig_idx;
    logic [3:0]        dig;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EXPECTED) ? {{(32-EXP_W){1'b0}}, r_expected} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_EXPECTED) begin
            r_expected <= pwdata[EXP_W-1:0];
        end
    end

    assign accept = i_s_tvalid && !r_b_valid;
    assign o_s_tready = !r_b_valid;

    sqlpm_lexer #(
        .MAX_TAG_CHARS     (MAX_TAG_CHARS),
        .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH),
        .MAX_MARKERS       (MAX_MARKERS)
    ) u_lexer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_text_byte     (i_s_tdata),
        .i_statement_end (i_s_tlast),
        .i_expected      (r_expected),
        .o_run           (run)
    );

    assign a_last_beat = r_beat == r_a.nbeats - BEAT_W'(1);
    assign a_done = r_a_valid && i_m_tready && a_last_beat;
    assign a_free = !r_a_valid || a_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_beat    <= '0;
        end else if (a_free) begin
            r_beat <= '0;
            if (r_b_valid) begin
                r_a       <= r_b;
                r_a_valid <= 1'b1;
                r_b_valid <= 1'b0;
            end else if (accept) begin
                r_a       <= run;
                r_a_valid <= 1'b1;
            end else begin
                r_a_valid <= 1'b0;
            end
        end else begin
            if (i_m_tready) begin
                r_beat <= r_beat + BEAT_W'(1);
            end
            if (accept) begin
                r_b       <= run;
                r_b_valid <= 1'b1;
            end
        end
    end

    // Digits leave most significant first after the leading '$'
    always_comb begin
        dig_idx = r_a.nbeats - BEAT_W'(1) - r_beat;
        case (dig_idx)
            3'd0:    dig = r_a.bcd[3:0];
            3'd1:    dig = r_a.bcd[7:4];
            3'd2:    dig = r_a.bcd[11:8];
            3'd3:    dig = r_a.bcd[15:12];
            3'd4:    dig = r_a.bcd[19:16];
            default: dig = 4'd0;
        endcase
    end

    always_comb begin
        o_m_tvalid = r_a_valid;
        if (!r_a.marker) begin
            o_m_tdata = r_a.byte_v;
        end else if (r_beat == '0) begin
            o_m_tdata = CH_DOLLAR;
        end else begin
            o_m_tdata = {CH_DIGIT_HI, dig};
        end
        o_m_tlast    = a_last_beat;
        o_m_tuser[0] = a_last_beat && r_a.done;
        o_m_tuser[1] = a_last_beat && r_a.mismatch;
        o_m_tuser[2] = r_a.too_long;
    end

`ifndef SYNTHESIS
    a_queue_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_a_valid)
        else $error("queued beat without an output run");
    a_beat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> r_beat < r_a.nbeats)
        else $error("beat index past end of run");
    a_marker_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a.marker |-> r_a.nbeats >= BEAT_W'(2) && r_a.nbeats <= BEAT_W'(6))
        else $error("marker run length out of range");
    a_mismatch_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a.mismatch |-> r_a.done)
        else $error("mismatch flagged before statement end");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !i_m_tready |=> r_a_valid && $stable(r_beat))
        else $error("beat advanced while stalled");
`endif

endmodule
